// ----- hdl/nrs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrs_pkg
// Shared types and constants of the nearest request scheduler.
// ----------------------------------------------------------------------------
package nrs_pkg;

    localparam int DEPTH      = 1024;
    localparam int POS_W      = 17;
    localparam int TOTAL_W    = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = IDX_W + 1;
    localparam int OP_W       = 2;
    localparam int IN_DATA_W  = ((POS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((POS_W + TOTAL_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_SERVE = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // one stored request: side bit and position
    typedef struct packed {
        logic             right;
        logic [POS_W-1:0] pos;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_mem_wr;

    typedef struct packed {
        logic [POS_W-1:0] a;
        logic [POS_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic             lt;
        logic             eq;
        logic [POS_W-1:0] delta;
    } t_alu_rsp;

endpackage

// ----- hdl/nrs_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrs_alu
// Shared compare / absolute difference unit used by the add, scan, distance and pick steps.
// ----------------------------------------------------------------------------
module nrs_alu (
    input  nrs_pkg::t_alu_req i_req,
    output nrs_pkg::t_alu_rsp o_rsp
);
    import nrs_pkg::*;

    logic [POS_W:0]   diff;
    logic [POS_W-1:0] neg;

    assign diff = {1'b0, i_req.a} - {1'b0, i_req.b};
    assign neg  = i_req.b - i_req.a;

    assign o_rsp.lt    = diff[POS_W];
    assign o_rsp.eq    = (diff == '0);
    assign o_rsp.delta = diff[POS_W] ? neg : diff[POS_W-1:0];

endmodule

// ----- hdl/nrs_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrs_store
// Pending request memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nrs_store (
    input  logic                        i_clk,
    input  nrs_pkg::t_mem_wr            i_wr,
    input  logic [nrs_pkg::IDX_W-1:0]   i_rd_addr,
    output nrs_pkg::t_entry             o_rd_data
);
    import nrs_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/nearest_request_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_request_scheduler
// Shortest-seek-first scheduler: stores request positions, serves the nearest.
// ----------------------------------------------------------------------------
// One item is taken at a time; o_s_axis_tready is high only while the
// sequencer is idle. Add passes through ST_ADD to ST_DONE, clear and unused
// codes go straight to ST_DONE, and serve walks the request store once
// through its single read port, one entry per cycle, feeding the one shared
// comparator, then finds both distances, picks a side and moves the last
// entry into the freed slot.
// Requests are kept packed at the low end of the store, so reset and clear
// are immediate. A finished result sits in the output register, so the next
// item can be taken while it waits for i_m_axis_tready.
module nearest_request_scheduler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [nrs_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,  // req_pos
    input  logic [nrs_pkg::OP_W-1:0]          i_s_axis_tuser,  // op
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [nrs_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,  // head_pos, travel_total
    output logic [nrs_pkg::OUT_USER_W-1:0]    o_m_axis_tuser   // served, dropped
);
    import nrs_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_ADD     = 9'b000000010,
        ST_SCAN    = 9'b000000100,
        ST_DR      = 9'b000001000,
        ST_DL      = 9'b000010000,
        ST_PICK    = 9'b000100000,
        ST_MOVE_RD = 9'b001000000,
        ST_MOVE_WR = 9'b010000000,
        ST_DONE    = 9'b100000000
    } t_state;

    t_state             r_state, n_state;
    logic [POS_W-1:0]   r_head, n_head;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic               r_mr, n_mr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_rd_vld, n_rd_vld;
    logic               r_m_valid, n_m_valid;

    logic [POS_W-1:0]   r_req_pos, n_req_pos;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_rd_idx, n_rd_idx;
    logic               r_have_r, n_have_r;
    logic               r_have_l, n_have_l;
    logic [POS_W-1:0]   r_best_r, n_best_r;
    logic [POS_W-1:0]   r_best_l, n_best_l;
    logic [IDX_W-1:0]   r_ri, n_ri;
    logic [IDX_W-1:0]   r_li, n_li;
    logic [POS_W-1:0]   r_dr, n_dr;
    logic [POS_W-1:0]   r_dl, n_dl;
    logic [IDX_W-1:0]   r_pick_idx, n_pick_idx;
    logic [POS_W-1:0]   r_dist, n_dist;
    logic               r_served, n_served;
    logic               r_dropped, n_dropped;
    logic               r_o_served, n_o_served;
    logic               r_o_dropped, n_o_dropped;
    logic [POS_W-1:0]   r_o_head, n_o_head;
    logic [TOTAL_W-1:0] r_o_total, n_o_total;

    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;
    t_mem_wr            mem_wr;
    logic [IDX_W-1:0]   rd_addr;
    t_entry             rd_data;
    logic               in_acc;
    logic               pick_r;
    logic [TOTAL_W:0]   sum;

    nrs_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    nrs_store u_store (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    assign sum = {1'b0, r_total} + {{(TOTAL_W + 1 - POS_W){1'b0}}, r_dist};

    // operand select for the shared unit
    always_comb begin
        alu_req = '0;
        case (r_state)
            ST_ADD: begin
                alu_req.a = r_req_pos;
                alu_req.b = r_head;
            end
            ST_SCAN: begin
                if (rd_data.right) begin
                    alu_req.a = rd_data.pos;
                    alu_req.b = r_best_r;
                end else begin
                    alu_req.a = r_best_l;
                    alu_req.b = rd_data.pos;
                end
            end
            ST_DR: begin
                alu_req.a = r_best_r;
                alu_req.b = r_head;
            end
            ST_DL: begin
                alu_req.a = r_head;
                alu_req.b = r_best_l;
            end
            ST_PICK: begin
                alu_req.a = r_dr;
                alu_req.b = r_dl;
            end
            default: alu_req = '0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_total     = r_total;
        n_mr        = r_mr;
        n_count     = r_count;
        n_rd_vld    = 1'b0;
        n_m_valid   = r_m_valid && !i_m_axis_tready;
        n_req_pos   = r_req_pos;
        n_idx       = r_idx;
        n_rd_idx    = r_rd_idx;
        n_have_r    = r_have_r;
        n_have_l    = r_have_l;
        n_best_r    = r_best_r;
        n_best_l    = r_best_l;
        n_ri        = r_ri;
        n_li        = r_li;
        n_dr        = r_dr;
        n_dl        = r_dl;
        n_pick_idx  = r_pick_idx;
        n_dist      = r_dist;
        n_served    = r_served;
        n_dropped   = r_dropped;
        n_o_served  = r_o_served;
        n_o_dropped = r_o_dropped;
        n_o_head    = r_o_head;
        n_o_total   = r_o_total;
        mem_wr      = '0;
        rd_addr     = r_idx[IDX_W-1:0];
        pick_r      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_req_pos = i_s_axis_tdata[POS_W-1:0];
                    n_served  = 1'b0;
                    n_dropped = 1'b0;
                    case (t_op'(i_s_axis_tuser))
                        OP_ADD: n_state = ST_ADD;
                        OP_SERVE: begin
                            n_idx    = '0;
                            n_have_r = 1'b0;
                            n_have_l = 1'b0;
                            n_state  = ST_SCAN;
                        end
                        OP_CLEAR: begin
                            n_head  = '0;
                            n_total = '0;
                            n_mr    = 1'b1;
                            n_count = '0;
                            n_state = ST_DONE;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_ADD: begin
                if (r_count == CNT_W'(DEPTH)) begin
                    n_dropped = 1'b1;
                end else begin
                    mem_wr.en         = 1'b1;
                    mem_wr.addr       = r_count[IDX_W-1:0];
                    mem_wr.data.right = !alu_rsp.lt;
                    mem_wr.data.pos   = r_req_pos;
                    n_count           = r_count + 1'b1;
                end
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                // entry read last cycle: keep the nearest on its side
                if (r_rd_vld) begin
                    if (rd_data.right) begin
                        if (!r_have_r || alu_rsp.lt) begin
                            n_have_r = 1'b1;
                            n_best_r = rd_data.pos;
                            n_ri     = r_rd_idx;
                        end
                    end else if (!r_have_l || alu_rsp.lt) begin
                        n_have_l = 1'b1;
                        n_best_l = rd_data.pos;
                        n_li     = r_rd_idx;
                    end
                end
                if (r_idx != r_count) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx[IDX_W-1:0];
                    n_idx    = r_idx + 1'b1;
                end else if (!r_rd_vld) begin
                    n_state = ST_DR;
                end
            end
            ST_DR: begin
                n_dr    = alu_rsp.delta;
                n_state = ST_DL;
            end
            ST_DL: begin
                n_dl    = alu_rsp.delta;
                n_state = ST_PICK;
            end
            ST_PICK: begin
                if (r_have_r && r_have_l) begin
                    if (alu_rsp.lt) begin
                        pick_r = 1'b1;
                        n_mr   = 1'b1;
                    end else if (alu_rsp.eq) begin
                        pick_r = r_mr;
                    end else begin
                        pick_r = 1'b0;
                        n_mr   = 1'b0;
                    end
                end else begin
                    pick_r = r_have_r;
                    n_mr   = r_have_r;
                end
                if (r_have_r || r_have_l) begin
                    n_dist     = pick_r ? r_dr : r_dl;
                    n_head     = pick_r ? r_best_r : r_best_l;
                    n_pick_idx = pick_r ? r_ri : r_li;
                    n_count    = r_count - 1'b1;
                    n_served   = 1'b1;
                    n_state    = ST_MOVE_RD;
                end else begin
                    n_mr    = r_mr;
                    n_state = ST_DONE;
                end
            end
            ST_MOVE_RD: begin
                // fetch the last entry to fill the freed slot
                rd_addr = r_count[IDX_W-1:0];
                n_total = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
                n_state = ST_MOVE_WR;
            end
            ST_MOVE_WR: begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = r_pick_idx;
                mem_wr.data = rd_data;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid   = 1'b1;
                    n_o_served  = r_served;
                    n_o_dropped = r_dropped;
                    n_o_head    = r_head;
                    n_o_total   = r_total;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_head    <= '0;
            r_total   <= '0;
            r_mr      <= 1'b1;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_total   <= n_total;
            r_mr      <= n_mr;
            r_count   <= n_count;
            r_rd_vld  <= n_rd_vld;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_pos   <= n_req_pos;
        r_idx       <= n_idx;
        r_rd_idx    <= n_rd_idx;
        r_have_r    <= n_have_r;
        r_have_l    <= n_have_l;
        r_best_r    <= n_best_r;
        r_best_l    <= n_best_l;
        r_ri        <= n_ri;
        r_li        <= n_li;
        r_dr        <= n_dr;
        r_dl        <= n_dl;
        r_pick_idx  <= n_pick_idx;
        r_dist      <= n_dist;
        r_served    <= n_served;
        r_dropped   <= n_dropped;
        r_o_served  <= n_o_served;
        r_o_dropped <= n_o_dropped;
        r_o_head    <= n_o_head;
        r_o_total   <= n_o_total;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - POS_W - TOTAL_W){1'b0}}, r_o_total, r_o_head};
    assign o_m_axis_tuser  = {r_o_dropped, r_o_served};

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("pending count beyond store depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= r_count))
        else $error("scan index ran past pending count");

    a_rd_vld_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == ST_SCAN))
        else $error("scan read data outside scan");

    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total < $past(r_total)) |->
            $past(in_acc && (i_s_axis_tuser == OP_CLEAR)))
        else $error("travel total decreased without clear");

endmodule
